// ===== rtl/core/rme_pkg.sv =====
// ----------------------------------------------------------------------------
// rme_pkg: shared types and constants of the register machine execute block
// Field widths, instruction modes, stop causes, stream layout and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package rme_pkg;

    localparam int DATA_W      = 32;
    localparam int LINE_W      = 10;
    localparam int MODE_W      = 4;
    localparam int CAUSE_W     = 3;
    localparam int REG_FIELD_W = 4;

    localparam logic [LINE_W-1:0] LAST_LINE_RESET = 10'd1023;
    localparam logic [LINE_W-1:0] PC_RESET        = 10'd1;

    // instruction modes
    localparam logic [MODE_W-1:0] MODE_ADD  = 4'd0;
    localparam logic [MODE_W-1:0] MODE_SUB  = 4'd1;
    localparam logic [MODE_W-1:0] MODE_MUL  = 4'd2;
    localparam logic [MODE_W-1:0] MODE_DIV  = 4'd3;
    localparam logic [MODE_W-1:0] MODE_CMP  = 4'd4;
    localparam logic [MODE_W-1:0] MODE_MOVE = 4'd5;
    localparam logic [MODE_W-1:0] MODE_BEQ  = 4'd6;
    localparam logic [MODE_W-1:0] MODE_BRZ  = 4'd7;
    localparam logic [MODE_W-1:0] MODE_JUMP = 4'd8;
    localparam logic [MODE_W-1:0] MODE_HALT = 4'd9;

    // stop causes
    localparam logic [CAUSE_W-1:0] CAUSE_NONE     = 3'd0;
    localparam logic [CAUSE_W-1:0] CAUSE_HALT     = 3'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_PAST_END = 3'd2;
    localparam logic [CAUSE_W-1:0] CAUSE_DIV_ZERO = 3'd3;
    localparam logic [CAUSE_W-1:0] CAUSE_BAD_REG  = 3'd4;

    // configuration port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam logic REG_LAST_LINE = 1'b0;

    // request stream layout (tdata)
    localparam int IN_MODE_LSB   = 0;
    localparam int IN_FIRST_LSB  = IN_MODE_LSB + MODE_W;
    localparam int IN_SECOND_LSB = IN_FIRST_LSB + DATA_W;
    localparam int IN_TARGET_LSB = IN_SECOND_LSB + DATA_W;
    localparam int IN_TDATA_W    = 80;
    localparam int IN_TUSER_W    = 2;
    localparam int IN_PAD_W      = IN_TDATA_W - (IN_TARGET_LSB + LINE_W);

    // result stream layout (tdata)
    localparam int OUT_NEXT_LSB  = 0;
    localparam int OUT_R0_LSB    = OUT_NEXT_LSB + LINE_W;
    localparam int OUT_WE_BIT    = OUT_R0_LSB + DATA_W;
    localparam int OUT_WR_LSB    = OUT_WE_BIT + 1;
    localparam int OUT_WD_LSB    = OUT_WR_LSB + REG_FIELD_W;
    localparam int OUT_CAUSE_LSB = OUT_WD_LSB + DATA_W;
    localparam int OUT_TDATA_W   = 88;
    localparam int OUT_PAD_W     = OUT_TDATA_W - (OUT_CAUSE_LSB + CAUSE_W);

    typedef struct packed {
        logic load;
        logic rd_sel_b;
        logic cap_a;
        logic cap_b;
        logic exec;
        logic div_cap;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic need_div;
        logic div_done;
        logic out_free;
    } t_status;

endpackage

// ===== rtl/core/rme_ram.sv =====
// ----------------------------------------------------------------------------
// rme_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/rme_div.sv =====
// ----------------------------------------------------------------------------
// rme_div: signed truncating divider
// Restoring division on magnitudes, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rme_div
    import rme_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DATA_W-1:0] i_dividend,
    input  logic [DATA_W-1:0] i_divisor,
    output logic              o_done,
    output logic [DATA_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DATA_W) + 1;

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_quo;
    logic [DATA_W-1:0] r_den;
    logic              r_neg;

    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   diff;
    logic              q_bit;

    assign shifted = {r_rem, r_quo[DATA_W-1]};
    assign diff    = shifted - {1'b0, r_den};
    assign q_bit   = ~diff[DATA_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DATA_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // operand magnitudes and running remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend[DATA_W-1] ? (DATA_W'(0) - i_dividend) : i_dividend;
            r_den <= i_divisor[DATA_W-1] ? (DATA_W'(0) - i_divisor) : i_divisor;
            r_rem <= '0;
            r_neg <= i_dividend[DATA_W-1] ^ i_divisor[DATA_W-1];
        end else if (r_busy) begin
            r_rem <= q_bit ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
            r_quo <= {r_quo[DATA_W-2:0], q_bit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? (DATA_W'(0) - r_quo) : r_quo;

endmodule

// ===== rtl/core/rme_datapath.sv =====
// ----------------------------------------------------------------------------
// rme_datapath: register file, program counter and execute logic
// Operand fetch, alu, divider, commit and result register.
// ----------------------------------------------------------------------------
module rme_datapath
    import rme_pkg::*;
#(
    parameter int NUM_REGS = 10
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    output t_status                o_status,
    input  logic [MODE_W-1:0]      i_mode,
    input  logic                   i_first_is_reg,
    input  logic [DATA_W-1:0]      i_first_value,
    input  logic                   i_second_is_reg,
    input  logic [DATA_W-1:0]      i_second_value,
    input  logic [LINE_W-1:0]      i_target_line,
    input  logic [LINE_W-1:0]      i_last_line,
    input  logic                   i_out_ready,
    output logic                   o_out_valid,
    output logic [LINE_W-1:0]      o_next_line,
    output logic [DATA_W-1:0]      o_r0_value,
    output logic                   o_write_enable,
    output logic [REG_FIELD_W-1:0] o_write_register,
    output logic [DATA_W-1:0]      o_write_data,
    output logic [CAUSE_W-1:0]     o_stop_cause
);

    localparam int IDX_W = $clog2(NUM_REGS);

    // latched request
    logic [MODE_W-1:0] r_mode;
    logic              r_f_reg;
    logic [DATA_W-1:0] r_f_val;
    logic              r_s_reg;
    logic [DATA_W-1:0] r_s_val;
    logic [LINE_W-1:0] r_target;

    // operands and pending result
    logic [DATA_W-1:0]  r_a;
    logic [DATA_W-1:0]  r_b;
    logic               r_we;
    logic [IDX_W-1:0]   r_wr;
    logic [DATA_W-1:0]  r_wd;
    logic [LINE_W-1:0]  r_pc_new;
    logic               r_stop_new;
    logic [CAUSE_W-1:0] r_code_new;

    // architectural state
    logic [LINE_W-1:0]   r_pc;
    logic                r_stopped;
    logic [CAUSE_W-1:0]  r_code;
    logic [DATA_W-1:0]   r_r0;
    logic [NUM_REGS-1:0] r_valid;
    logic                r_rd_valid;

    // result register
    logic                   r_out_valid;
    logic [LINE_W-1:0]      r_o_next;
    logic [DATA_W-1:0]      r_o_r0;
    logic                   r_o_we;
    logic [REG_FIELD_W-1:0] r_o_wr;
    logic [DATA_W-1:0]      r_o_wd;
    logic [CAUSE_W-1:0]     r_o_cause;

    logic              f_ok;
    logic              s_ok;
    logic [IDX_W-1:0]  f_addr;
    logic [IDX_W-1:0]  s_addr;
    logic [IDX_W-1:0]  rd_addr;
    logic [DATA_W-1:0] ram_rdata;
    logic [DATA_W-1:0] rf_data;
    logic              a_from_reg;
    logic              op_bad;
    logic              entry_bad;
    logic              b_zero;
    logic              need_div;
    logic [DATA_W-1:0] product;
    logic [LINE_W:0]   next_ln;
    logic              div_done;
    logic [DATA_W-1:0] quotient;
    logic [DATA_W-1:0] r0_after;

    logic               n_we;
    logic [IDX_W-1:0]   n_wr;
    logic [DATA_W-1:0]  n_wd;
    logic [LINE_W-1:0]  n_pc;
    logic               n_stop;
    logic [CAUSE_W-1:0] n_code;

    // register index checks, out-of-range indexes read entry zero
    assign f_ok    = r_f_val < DATA_W'(NUM_REGS);
    assign s_ok    = r_s_val < DATA_W'(NUM_REGS);
    assign f_addr  = f_ok ? r_f_val[IDX_W-1:0] : '0;
    assign s_addr  = s_ok ? r_s_val[IDX_W-1:0] : '0;
    assign rd_addr = i_cmd.rd_sel_b ? s_addr : f_addr;

    rme_ram #(
        .WIDTH (DATA_W),
        .DEPTH (NUM_REGS)
    ) u_rf (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit & r_we),
        .i_waddr (r_wr),
        .i_wdata (r_wd),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    // entries never written read as zero
    assign rf_data = r_rd_valid ? ram_rdata : '0;

    always_comb begin
        a_from_reg = r_f_reg;
        if (r_mode == MODE_MOVE || r_mode == MODE_BEQ) begin
            a_from_reg = 1'b1;
        end
    end

    always_comb begin
        op_bad = 1'b0;
        if (r_mode <= MODE_CMP) begin
            op_bad = (r_f_reg & ~f_ok) | (r_s_reg & ~s_ok);
        end else if (r_mode == MODE_MOVE || r_mode == MODE_BEQ) begin
            op_bad = ~f_ok | (r_s_reg & ~s_ok);
        end
    end

    assign entry_bad = (r_pc == '0) || (r_pc > i_last_line);
    assign b_zero    = (r_b == '0);
    assign need_div  = ~r_stopped & ~entry_bad & ~op_bad & (r_mode == MODE_DIV) & ~b_zero;
    assign product   = DATA_W'(r_a * r_b);
    assign next_ln   = {1'b0, r_pc} + 1'b1;

    rme_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.exec & need_div),
        .i_dividend (r_a),
        .i_divisor  (r_b),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    // execute decision
    always_comb begin
        logic [LINE_W:0] dest;
        dest   = next_ln;
        n_we   = 1'b0;
        n_wr   = '0;
        n_wd   = '0;
        n_pc   = r_pc;
        n_stop = 1'b1;
        n_code = r_code;
        if (r_stopped) begin
            n_code = r_code;
        end else if (entry_bad) begin
            n_code = CAUSE_PAST_END;
        end else if (op_bad) begin
            n_code = CAUSE_BAD_REG;
        end else if (r_mode == MODE_DIV && b_zero) begin
            n_code = CAUSE_DIV_ZERO;
        end else if (r_mode == MODE_HALT) begin
            n_code = CAUSE_HALT;
        end else begin
            case (r_mode)
                MODE_ADD: begin
                    n_we = 1'b1;
                    n_wd = r_a + r_b;
                end
                MODE_SUB: begin
                    n_we = 1'b1;
                    n_wd = r_a - r_b;
                end
                MODE_MUL: begin
                    n_we = 1'b1;
                    n_wd = product;
                end
                MODE_DIV: begin
                    // quotient lands later from the divider
                    n_we = 1'b1;
                end
                MODE_CMP: begin
                    n_we = 1'b1;
                    if (r_a == r_b) begin
                        n_wd = '0;
                    end else if ($signed(r_a) > $signed(r_b)) begin
                        n_wd = DATA_W'(1);
                    end else begin
                        n_wd = '1;
                    end
                end
                MODE_MOVE: begin
                    n_we = 1'b1;
                    n_wr = r_f_val[IDX_W-1:0];
                    n_wd = r_b;
                end
                MODE_BEQ: begin
                    if (r_a == r_b) begin
                        dest = {1'b0, r_target};
                    end
                end
                MODE_BRZ: begin
                    if (r_r0 == '0) begin
                        dest = {1'b0, r_target};
                    end
                end
                MODE_JUMP: begin
                    dest = {1'b0, r_target};
                end
                default: begin
                end
            endcase
            n_pc   = dest[LINE_W-1:0];
            n_stop = (dest == '0) || (dest > {1'b0, i_last_line});
            n_code = n_stop ? CAUSE_PAST_END : CAUSE_NONE;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode   <= i_mode;
            r_f_reg  <= i_first_is_reg;
            r_f_val  <= i_first_value;
            r_s_reg  <= i_second_is_reg;
            r_s_val  <= i_second_value;
            r_target <= i_target_line;
        end
        r_rd_valid <= r_valid[rd_addr];
        if (i_cmd.cap_a) begin
            r_a <= a_from_reg ? rf_data : r_f_val;
        end
        if (i_cmd.cap_b) begin
            r_b <= r_s_reg ? rf_data : r_s_val;
        end
        if (i_cmd.exec) begin
            r_we       <= n_we;
            r_wr       <= n_wr;
            r_wd       <= n_wd;
            r_pc_new   <= n_pc;
            r_stop_new <= n_stop;
            r_code_new <= n_code;
        end else if (i_cmd.div_cap) begin
            r_wd <= quotient;
        end
    end

    assign r0_after = (r_we && r_wr == '0) ? r_wd : r_r0;

    // architectural state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= PC_RESET;
            r_stopped   <= 1'b0;
            r_code      <= CAUSE_NONE;
            r_r0        <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_pc      <= r_pc_new;
                r_stopped <= r_stop_new;
                r_code    <= r_code_new;
                r_r0      <= r0_after;
                if (r_we) begin
                    r_valid[r_wr] <= 1'b1;
                end
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_o_next  <= r_pc_new;
            r_o_r0    <= r0_after;
            r_o_we    <= r_we;
            r_o_wr    <= REG_FIELD_W'(r_wr);
            r_o_wd    <= r_wd;
            r_o_cause <= r_stop_new ? r_code_new : CAUSE_NONE;
        end
    end

    assign o_status.need_div = need_div;
    assign o_status.div_done = div_done;
    assign o_status.out_free = ~r_out_valid | i_out_ready;

    assign o_out_valid      = r_out_valid;
    assign o_next_line      = r_o_next;
    assign o_r0_value       = r_o_r0;
    assign o_write_enable   = r_o_we;
    assign o_write_register = r_o_wr;
    assign o_write_data     = r_o_wd;
    assign o_stop_cause     = r_o_cause;

endmodule

// ===== rtl/core/rme_ctrl.sv =====
// ----------------------------------------------------------------------------
// rme_ctrl: instruction sequencer
// Steps one request through operand reads, execute, divide and commit.
// ----------------------------------------------------------------------------
module rme_ctrl
    import rme_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output t_cmd    o_cmd,
    input  t_status i_status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ_A,
        S_READ_B,
        S_LOAD_B,
        S_EXEC,
        S_DIV,
        S_COMMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_READ_A;
            S_READ_A: n_state = S_READ_B;
            S_READ_B: n_state = S_LOAD_B;
            S_LOAD_B: n_state = S_EXEC;
            S_EXEC:   n_state = i_status.need_div ? S_DIV : S_COMMIT;
            S_DIV:    if (i_status.div_done) n_state = S_COMMIT;
            S_COMMIT: if (i_status.out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_in_ready <= (n_state == S_IDLE);
        end
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = r_in_ready & i_in_valid;
        o_cmd.rd_sel_b = (r_state == S_READ_B);
        o_cmd.cap_a    = (r_state == S_READ_B);
        o_cmd.cap_b    = (r_state == S_LOAD_B);
        o_cmd.exec     = (r_state == S_EXEC);
        o_cmd.div_cap  = (r_state == S_DIV) & i_status.div_done;
        o_cmd.commit   = (r_state == S_COMMIT) & i_status.out_free;
    end

    assign o_in_ready = r_in_ready;

endmodule

// ===== rtl/core/toy_register_machine_execute.sv =====
// ----------------------------------------------------------------------------
// toy_register_machine_execute: execute stage of a ten-register toy machine
// Runs one decoded instruction per request against a register file and a
// program counter and reports the next line, R0 and the write it made.
// ----------------------------------------------------------------------------
// usage:
//   - requests enter on the s_axis channel, one decoded instruction each;
//     every request gives exactly one result on the m_axis channel
//   - a request passes operand read a, operand read b, operand load, execute
//     and commit; a divide also waits between execute and commit until the
//     bit-serial divider is done
//   - one request is worked on at a time; s_axis_tready rises again the cycle
//     after commit, so a new request is taken while the last result still
//     sits in the output register
//   - if m_axis_tready is low, the output register holds its result and the
//     next request waits in commit until that result is taken
//   - the register file sits in a small ram with one read port, so the two
//     operand reads are serialized; valid bits make never-written entries
//     read as zero
//   - after a stop (halt, past last line, divide by zero, bad register)
//     requests are still consumed and each returns the frozen state
//   - synchronous reset clears registers to zero, pc to line 1, the stop
//     flag, and sets last_line to 1023; no clearing sweep is needed
//   - last_line is written over the apb port at byte address 0
// ----------------------------------------------------------------------------
module toy_register_machine_execute
    import rme_pkg::*;
#(
    parameter int NUM_REGS = 10
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // request channel
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // mode, first_value, second_value, target_line, zero pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // first_is_reg, second_is_reg
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
    // result channel
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // next_line, r0_value, write_enable, write_register, write_data,
    // stop_cause, zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // configuration port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    t_cmd    cmd;
    t_status status;

    logic [LINE_W-1:0]      r_last_line;
    logic                   cfg_write;
    logic                   cfg_sel;

    logic [LINE_W-1:0]      next_line;
    logic [DATA_W-1:0]      r0_value;
    logic                   write_enable;
    logic [REG_FIELD_W-1:0] write_register;
    logic [DATA_W-1:0]      write_data;
    logic [CAUSE_W-1:0]     stop_cause;

    // register index is the word address; byte offset bits are ignored
    assign cfg_sel   = (paddr[APB_ADDR_W-1:2] == REG_LAST_LINE);
    assign cfg_write = psel & penable & pwrite;
    assign pready    = 1'b1;
    assign prdata    = cfg_sel ? APB_DATA_W'(r_last_line) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_line <= LAST_LINE_RESET;
        end else if (cfg_write && cfg_sel) begin
            r_last_line <= pwdata[LINE_W-1:0];
        end
    end

    rme_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd),
        .i_status   (status)
    );

    rme_datapath #(
        .NUM_REGS (NUM_REGS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_mode           (s_axis_tdata[IN_MODE_LSB +: MODE_W]),
        .i_first_is_reg   (s_axis_tuser[0]),
        .i_first_value    (s_axis_tdata[IN_FIRST_LSB +: DATA_W]),
        .i_second_is_reg  (s_axis_tuser[1]),
        .i_second_value   (s_axis_tdata[IN_SECOND_LSB +: DATA_W]),
        .i_target_line    (s_axis_tdata[IN_TARGET_LSB +: LINE_W]),
        .i_last_line      (r_last_line),
        .i_out_ready      (m_axis_tready),
        .o_out_valid      (m_axis_tvalid),
        .o_next_line      (next_line),
        .o_r0_value       (r0_value),
        .o_write_enable   (write_enable),
        .o_write_register (write_register),
        .o_write_data     (write_data),
        .o_stop_cause     (stop_cause)
    );

    assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, stop_cause, write_data, write_register,
                           write_enable, r0_value, next_line};

endmodule

// ===== rtl/core/rme_checker.sv =====
// ----------------------------------------------------------------------------
// rme_checker: port-level checks of the register machine execute block
// Watches the result channel and reset behavior.
// ----------------------------------------------------------------------------
module rme_checker
    import rme_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic                   we;
    logic [REG_FIELD_W-1:0] wr;
    logic [DATA_W-1:0]      wd;
    logic [CAUSE_W-1:0]     cause;

    assign we    = m_axis_tdata[OUT_WE_BIT];
    assign wr    = m_axis_tdata[OUT_WR_LSB +: REG_FIELD_W];
    assign wd    = m_axis_tdata[OUT_WD_LSB +: DATA_W];
    assign cause = m_axis_tdata[OUT_CAUSE_LSB +: CAUSE_W];

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // reset empties the result register
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // no write means empty write fields
    a_nowrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !we |-> wr == '0 && wd == '0)
        else $error("write fields set without write");

    // faults and halt never write
    a_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (cause == CAUSE_HALT || cause == CAUSE_DIV_ZERO ||
        cause == CAUSE_BAD_REG) |-> !we)
        else $error("write reported with a fault stop");

endmodule

bind toy_register_machine_execute rme_checker u_rme_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== dv/toy_register_machine_execute_tb.sv =====
// ----------------------------------------------------------------------------
// toy_register_machine_execute_tb: self-checking bench for the execute stage
// Streams decoded instructions into the block under bursty traffic and a
// stalling result sink, predicts every result from a cycle-free machine model,
// moves last_line across several settings between phases and ends the run
// with one randomly chosen stop condition followed by frozen-state requests.
// ----------------------------------------------------------------------------
module toy_register_machine_execute_tb;
    import rme_pkg::*;

    localparam int NREG           = 10;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 12;
    localparam logic [APB_ADDR_W-1:0] LAST_LINE_ADDR = APB_ADDR_W'(4 * REG_LAST_LINE);

    // last_line per random phase, 0 picks a random value; request count per phase
    localparam int unsigned LINE_CHOICES [7] = '{1023, 1, 40, 0, 1023, 7, 0};
    localparam int unsigned PHASE_ITEMS  [7] = '{400, 30, 250, 250, 300, 150, 150};

    // one decoded instruction as it rides the request channel
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              first_is_reg;
        logic [DATA_W-1:0] first_value;
        logic              second_is_reg;
        logic [DATA_W-1:0] second_value;
        logic [LINE_W-1:0] target_line;
    } t_instr;

    // what the block reports once an instruction retires
    typedef struct packed {
        logic [LINE_W-1:0]      next_line;
        logic [DATA_W-1:0]      r0_value;
        logic                   write_enable;
        logic [REG_FIELD_W-1:0] write_register;
        logic [DATA_W-1:0]      write_data;
        logic [CAUSE_W-1:0]     stop_cause;
    } t_retire;

    // architectural state of the machine plus its one configuration register
    typedef struct packed {
        logic [NREG-1:0][DATA_W-1:0] regs;
        logic [LINE_W-1:0]           pc;
        logic                        halted;
        logic [CAUSE_W-1:0]          cause;
        logic [LINE_W-1:0]           last_line;
    } t_machine;

    // the way the run is brought to its stop at the very end
    typedef enum int {
        STOP_BY_HALT,
        STOP_BY_DIV_ZERO,
        STOP_BY_BAD_REG,
        STOP_BY_LEAVING_PROGRAM,
        STOP_ON_ENTRY
    } t_stop_drill;

    // clock, reset and every block input start at a known value
    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr = '0;
    logic [APB_DATA_W-1:0]  pwdata = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    // live: advanced at each accepted request; plan: advanced as stimulus is built
    t_machine    live;
    t_machine    plan;
    t_instr      pending_requests [$];
    t_retire     results_due [$];
    int unsigned fail_count = 0;
    int unsigned requests_taken = 0;
    int unsigned results_checked = 0;
    int unsigned settings_used = 0;
    int unsigned quiet_cycles = 0;
    int unsigned burst_left = 1;
    int unsigned gap_left = 0;
    logic [15:0] stall_pattern = 16'hFFFF;
    int unsigned pattern_age = 0;
    t_stop_drill drill;

    always #10 i_clk = ~i_clk;

    toy_register_machine_execute #(
        .NUM_REGS(NREG)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // ------------------------------------------------------------------------
    // machine model
    // ------------------------------------------------------------------------

    function automatic t_machine reset_machine();
        t_machine m;
        m           = '0;
        m.pc        = PC_RESET;
        m.last_line = LAST_LINE_RESET;
        return m;
    endfunction

    // a line outside 1..last_line ends the program; one extra bit for pc + 1
    function automatic logic line_outside(logic [LINE_W:0] line, logic [LINE_W-1:0] last);
        return line == '0 || line > {1'b0, last};
    endfunction

    // register index is taken unsigned over the full 32 bits
    function automatic logic reg_index_ok(logic [DATA_W-1:0] idx);
        return idx < DATA_W'(NREG);
    endfunction

    // register read or immediate; flags an out-of-range index
    function automatic logic [DATA_W-1:0] operand_value(t_machine m, logic is_reg,
                                                        logic [DATA_W-1:0] v, inout logic bad);
        if (!is_reg)
            return v;
        if (!reg_index_ok(v)) begin
            bad = 1'b1;
            return '0;
        end
        return m.regs[v[REG_FIELD_W-1:0]];
    endfunction

    // truncating signed divide on magnitudes, so the most negative / -1 wraps
    function automatic logic [DATA_W-1:0] quotient(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
        logic [DATA_W-1:0] ma;
        logic [DATA_W-1:0] mb;
        logic [DATA_W-1:0] q;
        ma = a[DATA_W-1] ? -a : a;
        mb = b[DATA_W-1] ? -b : b;
        q  = ma / mb;
        return (a[DATA_W-1] ^ b[DATA_W-1]) ? -q : q;
    endfunction

    // runs one instruction against the machine state and returns its result
    function automatic t_retire execute_instr(inout t_machine m, input t_instr ins);
        t_retire           r;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [LINE_W:0]   nxt;
        logic              bad;
        r   = '0;
        a   = '0;
        b   = '0;
        bad = 1'b0;
        nxt = {1'b0, m.pc} + 1'b1;

        // a pc already outside the program stops before anything runs
        if (!m.halted && line_outside({1'b0, m.pc}, m.last_line)) begin
            m.halted = 1'b1;
            m.cause  = CAUSE_PAST_END;
        end

        if (!m.halted) begin
            if (ins.mode <= MODE_CMP) begin
                a = operand_value(m, ins.first_is_reg, ins.first_value, bad);
                b = operand_value(m, ins.second_is_reg, ins.second_value, bad);
            end else if (ins.mode == MODE_MOVE || ins.mode == MODE_BEQ) begin
                // first operand always names a register here, its flag is ignored
                if (!reg_index_ok(ins.first_value))
                    bad = 1'b1;
                b = operand_value(m, ins.second_is_reg, ins.second_value, bad);
                if (!bad)
                    a = m.regs[ins.first_value[REG_FIELD_W-1:0]];
            end

            if (bad) begin
                m.halted = 1'b1;
                m.cause  = CAUSE_BAD_REG;
            end else if (ins.mode == MODE_DIV && b == '0) begin
                m.halted = 1'b1;
                m.cause  = CAUSE_DIV_ZERO;
            end else if (ins.mode == MODE_HALT) begin
                m.halted = 1'b1;
                m.cause  = CAUSE_HALT;
            end else begin
                case (ins.mode)
                    MODE_ADD: begin
                        r.write_enable = 1'b1;
                        r.write_data   = a + b;
                    end
                    MODE_SUB: begin
                        r.write_enable = 1'b1;
                        r.write_data   = a - b;
                    end
                    MODE_MUL: begin
                        r.write_enable = 1'b1;
                        r.write_data   = a * b;
                    end
                    MODE_DIV: begin
                        r.write_enable = 1'b1;
                        r.write_data   = quotient(a, b);
                    end
                    MODE_CMP: begin
                        r.write_enable = 1'b1;
                        if (a == b)
                            r.write_data = '0;
                        else
                            r.write_data = ($signed(a) > $signed(b)) ? DATA_W'(1) : '1;
                    end
                    MODE_MOVE: begin
                        r.write_enable   = 1'b1;
                        r.write_register = ins.first_value[REG_FIELD_W-1:0];
                        r.write_data     = b;
                    end
                    MODE_BEQ: begin
                        if (a == b)
                            nxt = {1'b0, ins.target_line};
                    end
                    MODE_BRZ: begin
                        if (m.regs[0] == '0)
                            nxt = {1'b0, ins.target_line};
                    end
                    MODE_JUMP: nxt = {1'b0, ins.target_line};
                    default: ;
                endcase
                if (r.write_enable)
                    m.regs[r.write_register] = r.write_data;
                // effects stand even when the next line leaves the program
                m.pc = nxt[LINE_W-1:0];
                if (line_outside(nxt, m.last_line)) begin
                    m.halted = 1'b1;
                    m.cause  = CAUSE_PAST_END;
                end
            end
        end

        r.next_line  = m.pc;
        r.r0_value   = m.regs[0];
        r.stop_cause = m.halted ? m.cause : CAUSE_NONE;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------------

    function automatic t_instr make_instr(logic [MODE_W-1:0] mode, logic f_reg,
                                          logic [DATA_W-1:0] f_val, logic s_reg,
                                          logic [DATA_W-1:0] s_val, logic [LINE_W-1:0] target);
        t_instr ins;
        ins.mode          = mode;
        ins.first_is_reg  = f_reg;
        ins.first_value   = f_val;
        ins.second_is_reg = s_reg;
        ins.second_value  = s_val;
        ins.target_line   = target;
        return ins;
    endfunction

    // mostly register reads, else small, extreme or fully random immediates
    function automatic void random_operand(output logic is_reg, output logic [DATA_W-1:0] v);
        is_reg = $urandom_range(0, 99) < 55;
        if (is_reg)
            v = DATA_W'($urandom_range(0, NREG - 1));
        else begin
            case ($urandom_range(0, 3))
                0: v = DATA_W'($urandom_range(0, 40)) - DATA_W'(20);
                1: begin
                    case ($urandom_range(0, 3))
                        0: v = 32'h8000_0000;
                        1: v = 32'h7FFF_FFFF;
                        2: v = '1;
                        default: v = '0;
                    endcase
                end
                default: v = $urandom;
            endcase
        end
    endfunction

    // jump with random noise in the unused operand fields
    function automatic t_instr jump_to(logic [LINE_W-1:0] line);
        t_instr ins;
        ins             = '0;
        ins.mode        = MODE_JUMP;
        random_operand(ins.first_is_reg, ins.first_value);
        random_operand(ins.second_is_reg, ins.second_value);
        ins.target_line = line;
        return ins;
    endfunction

    // random instruction shaped by the planned state so branches land in range
    function automatic t_instr random_instr(t_machine p);
        t_instr      ins;
        int unsigned lo;
        int unsigned hi;
        if ($urandom_range(0, 19) == 0)
            ins.mode = MODE_W'($urandom_range(MODE_HALT + 1, 2 ** MODE_W - 1));
        else
            ins.mode = MODE_W'($urandom_range(MODE_ADD, MODE_JUMP));
        random_operand(ins.first_is_reg, ins.first_value);
        random_operand(ins.second_is_reg, ins.second_value);

        if (ins.mode == MODE_MOVE || ins.mode == MODE_BEQ)
            ins.first_value = DATA_W'($urandom_range(0, NREG - 1));
        // half of the equality branches are made to be taken
        if (ins.mode == MODE_BEQ && $urandom_range(0, 1) == 1) begin
            ins.second_is_reg = 1'b0;
            ins.second_value  = p.regs[ins.first_value[REG_FIELD_W-1:0]];
        end

        // targets either near the current line or anywhere in the program
        if ($urandom_range(0, 1) == 1) begin
            lo = (p.pc > 6) ? p.pc - 6 : 1;
            hi = (p.pc + 6 < p.last_line) ? p.pc + 6 : p.last_line;
            ins.target_line = LINE_W'($urandom_range(lo, hi));
        end else
            ins.target_line = LINE_W'($urandom_range(1, p.last_line));
        return ins;
    endfunction

    // draws until the instruction keeps the machine running; a stop can not
    // be undone without reset, so stops are kept for the end of the run
    function automatic t_instr next_safe_instr(inout t_machine p);
        t_machine trial;
        t_instr   cand;
        t_retire  r;
        for (int k = 0; k < 24; k++) begin
            cand  = random_instr(p);
            trial = p;
            r     = execute_instr(trial, cand);
            if (r.stop_cause == CAUSE_NONE) begin
                p = trial;
                return cand;
            end
        end
        // line 1 is valid for every last_line setting
        cand = jump_to(LINE_W'(1));
        void'(execute_instr(p, cand));
        return cand;
    endfunction

    task automatic issue(input t_instr ins);
        void'(execute_instr(plan, ins));
        pending_requests.push_back(ins);
    endtask

    // setup then access cycle; a read samples prdata at the access edge
    task automatic apb_access(input logic write, input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= LAST_LINE_ADDR;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // only called while the block is idle, so both models take it at once
    task automatic set_last_line(input logic [LINE_W-1:0] line);
        logic [APB_DATA_W-1:0] readback;
        apb_access(1'b1, APB_DATA_W'(line), readback);
        apb_access(1'b0, '0, readback);
        if (readback !== APB_DATA_W'(line)) begin
            $error("last_line readback: expected %0d, actual %0d", line, readback);
            fail_count++;
        end
        live.last_line = line;
        plan.last_line = line;
        settings_used++;
    endtask

    // sender pauses until every request is taken and every result is back
    task automatic wait_drained();
        @(negedge i_clk);
        while (pending_requests.size() != 0 || s_axis_tvalid || results_due.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // request driver: bursts of random length, random gaps between them
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : request_driver
        t_instr ins;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
            burst_left    = 1;
            gap_left      = 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (gap_left != 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
                ins = pending_requests.pop_front();
                s_axis_tdata  <= {{IN_PAD_W{1'b0}}, ins.target_line, ins.second_value,
                                  ins.first_value, ins.mode};
                s_axis_tuser  <= {ins.second_is_reg, ins.first_is_reg};
                s_axis_tvalid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 24);
                    // some bursts run straight into the next one
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end else
                    burst_left--;
            end else
                s_axis_tvalid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // result sink: a rotating stall pattern, reshuffled every so often
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_sink
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_pattern = 16'hFFFF;
            pattern_age   = 0;
        end else begin
            if (pattern_age == 0) begin
                // a quarter of the time no stalls at all; never all stalls
                if ($urandom_range(0, 3) == 0)
                    stall_pattern = 16'hFFFF;
                else
                    stall_pattern = 16'($urandom) | (16'h1 << $urandom_range(0, 15));
                pattern_age = $urandom_range(32, 128);
            end else
                pattern_age--;
            m_axis_tready <= stall_pattern[0];
            stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
        end
    end

    // ------------------------------------------------------------------------
    // monitor: predict on each accepted request, check each accepted result
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_checker
        t_instr  seen;
        t_retire got;
        t_retire want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                seen.mode          = s_axis_tdata[IN_MODE_LSB +: MODE_W];
                seen.first_value   = s_axis_tdata[IN_FIRST_LSB +: DATA_W];
                seen.second_value  = s_axis_tdata[IN_SECOND_LSB +: DATA_W];
                seen.target_line   = s_axis_tdata[IN_TARGET_LSB +: LINE_W];
                seen.first_is_reg  = s_axis_tuser[0];
                seen.second_is_reg = s_axis_tuser[1];
                results_due.push_back(execute_instr(live, seen));
                requests_taken++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.next_line      = m_axis_tdata[OUT_NEXT_LSB +: LINE_W];
                got.r0_value       = m_axis_tdata[OUT_R0_LSB +: DATA_W];
                got.write_enable   = m_axis_tdata[OUT_WE_BIT];
                got.write_register = m_axis_tdata[OUT_WR_LSB +: REG_FIELD_W];
                got.write_data     = m_axis_tdata[OUT_WD_LSB +: DATA_W];
                got.stop_cause     = m_axis_tdata[OUT_CAUSE_LSB +: CAUSE_W];
                if (results_due.size() == 0) begin
                    $error("result with no request outstanding");
                    fail_count++;
                end else begin
                    want = results_due.pop_front();
                    results_checked++;
                    if (got.next_line !== want.next_line) begin
                        $error("next_line: expected %0d, actual %0d",
                               want.next_line, got.next_line);
                        fail_count++;
                    end
                    if (got.r0_value !== want.r0_value) begin
                        $error("r0_value: expected %h, actual %h", want.r0_value, got.r0_value);
                        fail_count++;
                    end
                    if (got.write_enable !== want.write_enable) begin
                        $error("write_enable: expected %0d, actual %0d",
                               want.write_enable, got.write_enable);
                        fail_count++;
                    end
                    if (got.write_register !== want.write_register) begin
                        $error("write_register: expected %0d, actual %0d",
                               want.write_register, got.write_register);
                        fail_count++;
                    end
                    if (got.write_data !== want.write_data) begin
                        $error("write_data: expected %h, actual %h",
                               want.write_data, got.write_data);
                        fail_count++;
                    end
                    if (got.stop_cause !== want.stop_cause) begin
                        $error("stop_cause: expected %0d, actual %0d",
                               want.stop_cause, got.stop_cause);
                        fail_count++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: too long without any handshake or config access ends the run
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : hang_watchdog
        if (!i_rst_n || psel || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[toy_register_machine_execute] ERROR");
            $finish;
        end else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial begin : test_sequence
        logic [LINE_W-1:0] line;
        t_instr            ins;
        live = reset_machine();
        plan = reset_machine();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_last_line(LAST_LINE_RESET);
        @(negedge i_clk);

        // directed: wrapping arithmetic, divide corner cases, all compare
        // outcomes, moves, taken and untaken branches, unknown modes
        issue(make_instr(MODE_ADD, 1'b0, 32'h7FFF_FFFF, 1'b0, 32'd1, 10'd0));
        issue(make_instr(MODE_SUB, 1'b0, 32'h8000_0000, 1'b0, 32'd1, 10'd1023));
        issue(make_instr(MODE_MUL, 1'b0, 32'h8000_0000, 1'b1, 32'd0, 10'd0));
        issue(make_instr(MODE_DIV, 1'b0, 32'h8000_0000, 1'b0, 32'hFFFF_FFFF, 10'd0));
        issue(make_instr(MODE_DIV, 1'b0, -32'sd7, 1'b0, 32'd2, 10'd0));
        issue(make_instr(MODE_DIV, 1'b0, 32'd7, 1'b0, -32'sd2, 10'd0));
        issue(make_instr(MODE_CMP, 1'b0, 32'h7FFF_FFFF, 1'b0, 32'h8000_0000, 10'd0));
        issue(make_instr(MODE_CMP, 1'b0, 32'h8000_0000, 1'b0, 32'h7FFF_FFFF, 10'd0));
        issue(make_instr(MODE_CMP, 1'b1, 32'd0, 1'b1, 32'd0, 10'd0));
        issue(make_instr(MODE_MOVE, 1'b0, 32'd9, 1'b0, 32'h1234_5678, 10'd0));
        issue(make_instr(MODE_MOVE, 1'b1, 32'd3, 1'b1, 32'd9, 10'd0));
        issue(make_instr(MODE_ADD, 1'b1, 32'd3, 1'b1, 32'd9, 10'd0));
        issue(make_instr(MODE_BEQ, 1'b1, 32'd3, 1'b0, 32'h1234_5678, 10'd500));
        issue(make_instr(MODE_BEQ, 1'b0, 32'd3, 1'b1, 32'd0, 10'd2));
        issue(make_instr(MODE_MOVE, 1'b1, 32'd0, 1'b0, 32'd0, 10'd0));
        issue(make_instr(MODE_BRZ, 1'b0, 32'd0, 1'b0, 32'd0, 10'd1000));
        issue(make_instr(MODE_MOVE, 1'b1, 32'd0, 1'b0, 32'hFFFF_FFFF, 10'd0));
        issue(make_instr(MODE_BRZ, 1'b0, 32'd0, 1'b0, 32'd0, 10'd3));
        issue(make_instr(MODE_JUMP, 1'b0, 32'd0, 1'b0, 32'd0, 10'd1023));
        // at the last line only a taken branch keeps the machine alive
        issue(make_instr(MODE_BEQ, 1'b1, 32'd0, 1'b1, 32'd0, 10'd2));
        issue(make_instr(MODE_W'(MODE_HALT + 1), 1'b1, 32'd5, 1'b0, 32'd5, 10'd9));
        issue(make_instr(4'hF, 1'b0, 32'hFFFF_FFFF, 1'b1, 32'd9, 10'd1023));
        issue(make_instr(MODE_MUL, 1'b1, 32'd9, 1'b0, 32'hFFFF_FFFF, 10'd0));
        issue(jump_to(LINE_W'(1)));
        wait_drained();

        // random phases under changing last_line; each ends back on line 1
        // so the next setting never leaves pc outside the program
        for (int ph = 0; ph < 7; ph++) begin
            line = (LINE_CHOICES[ph] == 0) ? LINE_W'($urandom_range(2, 1022))
                                           : LINE_W'(LINE_CHOICES[ph]);
            set_last_line(line);
            @(negedge i_clk);
            for (int n = 0; n < PHASE_ITEMS[ph]; n++)
                pending_requests.push_back(next_safe_instr(plan));
            issue(jump_to(LINE_W'(1)));
            wait_drained();
        end

        // one stop condition per run, then requests against the frozen state
        set_last_line(LAST_LINE_RESET);
        @(negedge i_clk);
        drill = t_stop_drill'($urandom_range(STOP_BY_HALT, STOP_ON_ENTRY));
        ins   = random_instr(plan);
        case (drill)
            STOP_BY_HALT: ins.mode = MODE_HALT;
            STOP_BY_DIV_ZERO: begin
                ins.mode          = MODE_DIV;
                ins.second_is_reg = 1'b0;
                ins.second_value  = '0;
            end
            STOP_BY_BAD_REG: begin
                ins.mode = MODE_W'($urandom_range(MODE_ADD, MODE_BEQ));
                // either operand may carry the bad index, just past or far out
                if ($urandom_range(0, 1) == 1) begin
                    ins.first_is_reg = 1'b1;
                    ins.first_value  = ($urandom_range(0, 1) == 1)
                                       ? DATA_W'($urandom_range(NREG, 15))
                                       : ($urandom | 32'h10);
                end else begin
                    ins.second_is_reg = 1'b1;
                    ins.second_value  = ($urandom_range(0, 1) == 1)
                                        ? DATA_W'($urandom_range(NREG, 15))
                                        : ($urandom | 32'h10);
                end
            end
            STOP_BY_LEAVING_PROGRAM: begin
                // jump to line 0, or step off the last line so pc wraps to 0
                if ($urandom_range(0, 1) == 1)
                    ins = jump_to('0);
                else begin
                    issue(jump_to(LAST_LINE_RESET));
                    ins.mode = MODE_ADD;
                end
            end
            default: begin
                // pc parked high, then last_line pulled below it
                issue(jump_to(LINE_W'(700)));
                wait_drained();
                set_last_line(LINE_W'($urandom_range(1, 699)));
                @(negedge i_clk);
            end
        endcase
        issue(ins);
        repeat (6) issue(random_instr(plan));
        wait_drained();

        if (results_due.size() != 0) begin
            $error("%0d results never arrived", results_due.size());
            fail_count++;
        end
        $display("ran %0d instructions under %0d last_line settings, %0d results checked",
                 requests_taken, settings_used, results_checked);
        $display("run ended through %s with stop cause %0d", drill.name(), live.cause);
        if (fail_count == 0)
            $display("[toy_register_machine_execute] OK");
        else
            $display("[toy_register_machine_execute] ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/rme_pkg.sv
rtl/core/rme_ram.sv
rtl/core/rme_div.sv
rtl/core/rme_datapath.sv
rtl/core/rme_ctrl.sv
rtl/core/toy_register_machine_execute.sv
rtl/core/rme_checker.sv
dv/toy_register_machine_execute_tb.sv
